### rtl/pending_request_table_aging_defines.svh
// Assertion macros shared by the pending request table RTL.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef PENDING_REQUEST_TABLE_AGING_DEFINES_SVH
`define PENDING_REQUEST_TABLE_AGING_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define PRTA_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pending_request_table_aging: check failed");
// Next-cycle implication, disabled during reset.
`define PRTA_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pending_request_table_aging: check failed");
`else
`define PRTA_ASSERT_IMP(name, clk, rstn, ante, cons)
`define PRTA_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

### rtl/prta_pkg.sv
// Types and constants of the pending request table.
// No dependencies; imported by the top level.
package prta_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int KEY_BYTES_DEF = 8;

    localparam int OP_W       = 3;
    localparam int KEY_FULL_W = 64;
    localparam int TTL_W      = 16;
    localparam int CNT_OUT_W  = 5;
    localparam int S_TDATA_W  = 184;
    localparam int M_TDATA_W  = 192;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_POP    = 3'd2,
        OP_DROP   = 3'd3,
        OP_PRUNE  = 3'd4
    } prta_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_DONE
    } prta_state_t;

    // Per-slot payload apart from the key.
    typedef struct packed {
        logic [31:0] req_id;
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] seen;
    } prta_info_t;

    localparam int INFO_W = $bits(prta_info_t);

endpackage

### rtl/prta_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the slot payloads of the pending request table.
module prta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pending_request_table_aging.sv
// Channel   | Group   | Contents (lowest bit first)
// ----------+---------+-----------------------------------------------------------
// command   | s_axis  | tuser: op; tdata: node_key, req_id, peer_addr, peer_port,
//           |         |        now_time, drop_limit
// result    | m_axis  | tuser: status; tdata: removed_count, got_key, got_req_id,
//           |         |        got_addr, got_port, got_seen, occupancy
// ttl       | cfg     | cfg_we / cfg_wdata: ttl_limit (age limit in seconds)
//
// A scan command reads every slot through the one RAM read port, which feeds one
// slot per cycle to the compare unit. Drop repeats the pass until the limit or an
// empty pass. A full add, a zero drop and an unknown op skip the scan entirely.
// Reset (aresetn low, synchronous) empties the table at once; no clearing pass.
// s_tready rises with m_tvalid; a waiting result does not block the next transfer.
//
// Top level of the pending request table. Depends on prta_pkg, prta_ram and
// the assertion macros in pending_request_table_aging_defines.svh.
`include "pending_request_table_aging_defines.svh"

module pending_request_table_aging #(
    parameter int SLOTS     = prta_pkg::SLOTS_DEF,
    parameter int KEY_BYTES = prta_pkg::KEY_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // ttl_limit
    input  logic                            cfg_we,
    input  logic [prta_pkg::TTL_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // node_key[63:0], req_id[95:64], peer_addr[127:96], peer_port[143:128],
    // now_time[175:144], drop_limit[180:176], zero fill above
    input  logic [prta_pkg::S_TDATA_W-1:0]  s_tdata,
    // op[2:0]
    input  logic [prta_pkg::OP_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // removed_count[4:0], got_key[68:5], got_req_id[100:69], got_addr[132:101],
    // got_port[148:133], got_seen[180:149], occupancy[185:181], zero fill above
    output logic [prta_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[0]
    output logic                            m_tuser
);

    import prta_pkg::*;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int KEY_W  = 8 * KEY_BYTES;
    localparam int WORD_W = KEY_W + INFO_W;

    // Control state.
    prta_state_t         state_reg, state_next;
    logic [SLOTS-1:0]    used_reg, used_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TTL_W-1:0]    ttl_reg, ttl_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                beat_vld_reg, beat_vld_next;
    logic                hit_reg, hit_next;
    logic                free_reg, free_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // Command and scan payload.
    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    prta_info_t          info_reg, info_next;
    logic [4:0]          limit_reg, limit_next;
    logic [4:0]          removed_reg, removed_next;
    logic                status_reg, status_next;
    logic [IDX_W-1:0]    beat_idx_reg, beat_idx_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [KEY_W-1:0]    best_key_reg, best_key_next;
    prta_info_t          best_info_reg, best_info_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    // Table RAM ports.
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;

    // Slot under the compare unit this cycle.
    logic [KEY_W-1:0]    rd_key;
    prta_info_t          rd_info;
    logic                rd_used;
    logic [31:0]         rd_age;
    logic                issuing;
    logic                got_shown;

    prta_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[INFO_W +: KEY_W];
    assign rd_info  = prta_info_t'(ram_rdata[INFO_W-1:0]);
    assign rd_used  = used_reg[beat_idx_reg];
    // Wrapping age: the subtraction is taken modulo 2^32 on purpose.
    assign rd_age   = info_reg.seen - rd_info.seen;
    assign issuing  = (state_reg == ST_SCAN) && (issue_reg != CNT_W'(SLOTS));
    assign got_shown = (op_reg == OP_POP) && !status_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        count_next     = count_reg;
        ttl_next       = cfg_we ? cfg_wdata : ttl_reg;
        issue_next     = issue_reg;
        beat_vld_next  = issuing;
        beat_idx_next  = issue_reg[IDX_W-1:0];
        hit_next       = hit_reg;
        free_next      = free_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        op_next        = op_reg;
        key_next       = key_reg;
        info_next      = info_reg;
        limit_next     = limit_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        hit_idx_next   = hit_idx_reg;
        free_idx_next  = free_idx_reg;
        best_key_next  = best_key_reg;
        best_info_next = best_info_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        ram_we         = 1'b0;
        ram_waddr      = hit_reg ? hit_idx_reg : free_idx_reg;
        ram_wdata      = {key_reg, info_reg};

        if (issuing) begin
            issue_next = issue_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    // Only the low KEY_BYTES bytes of the key are kept.
                    op_next          = s_tuser;
                    key_next         = s_tdata[KEY_W-1:0];
                    info_next.req_id = s_tdata[95:64];
                    info_next.addr   = s_tdata[127:96];
                    info_next.port   = s_tdata[143:128];
                    info_next.seen   = s_tdata[175:144];
                    limit_next       = s_tdata[180:176];
                    removed_next     = '0;
                    status_next      = 1'b1;
                    issue_next       = '0;
                    hit_next         = 1'b0;
                    free_next        = 1'b0;
                    case (s_tuser)
                        OP_ADD: begin
                            // A full table refuses the add even for a present key.
                            state_next = (count_reg == CNT_W'(SLOTS)) ? ST_DONE : ST_SCAN;
                        end
                        OP_REMOVE, OP_POP, OP_PRUNE: begin
                            state_next = ST_SCAN;
                        end
                        OP_DROP: begin
                            if (s_tdata[180:176] == 5'd0) begin
                                status_next = 1'b0;
                                state_next  = ST_DONE;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (beat_vld_reg) begin
                    case (op_reg)
                        OP_ADD, OP_REMOVE: begin
                            if (rd_used && (rd_key == key_reg) && !hit_reg) begin
                                hit_next     = 1'b1;
                                hit_idx_next = beat_idx_reg;
                            end
                            if (!rd_used && !free_reg) begin
                                free_next     = 1'b1;
                                free_idx_next = beat_idx_reg;
                            end
                        end
                        OP_POP, OP_DROP: begin
                            // Strictly older only, so ties keep the lowest slot.
                            if (rd_used && (!hit_reg || (rd_info.seen < best_info_reg.seen)))
                            begin
                                hit_next       = 1'b1;
                                hit_idx_next   = beat_idx_reg;
                                best_key_next  = rd_key;
                                best_info_next = rd_info;
                            end
                        end
                        OP_PRUNE: begin
                            if (rd_used && (rd_age > 32'(ttl_reg))) begin
                                used_next[beat_idx_reg] = 1'b0;
                                count_next   = count_reg - 1'b1;
                                removed_next = removed_reg + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (beat_idx_reg == IDX_W'(SLOTS - 1)) begin
                        state_next = ST_EVAL;
                    end
                end
            end

            ST_EVAL: begin
                state_next = ST_DONE;
                case (op_reg)
                    OP_ADD: begin
                        // Refresh the matching slot, else claim the lowest free one.
                        ram_we                = 1'b1;
                        used_next[ram_waddr]  = 1'b1;
                        status_next           = 1'b0;
                        if (!hit_reg) begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    OP_REMOVE, OP_POP: begin
                        if (hit_reg) begin
                            used_next[hit_idx_reg] = 1'b0;
                            count_next  = count_reg - 1'b1;
                            status_next = 1'b0;
                        end
                    end
                    OP_DROP: begin
                        status_next = 1'b0;
                        if (hit_reg) begin
                            used_next[hit_idx_reg] = 1'b0;
                            count_next   = count_reg - 1'b1;
                            removed_next = removed_reg + 1'b1;
                            if ((removed_reg + 5'd1) < limit_reg) begin
                                issue_next = '0;
                                hit_next   = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                    end
                    OP_PRUNE: begin
                        status_next = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next          = 1'b1;
                    m_tuser_next           = status_reg;
                    m_tdata_next           = '0;
                    m_tdata_next[4:0]      = removed_reg;
                    m_tdata_next[185:181]  = CNT_OUT_W'(count_reg);
                    if (got_shown) begin
                        m_tdata_next[68:5]    = KEY_FULL_W'(best_key_reg);
                        m_tdata_next[100:69]  = best_info_reg.req_id;
                        m_tdata_next[132:101] = best_info_reg.addr;
                        m_tdata_next[148:133] = best_info_reg.port;
                        m_tdata_next[180:149] = best_info_reg.seen;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            count_reg    <= '0;
            ttl_reg      <= TTL_W'(30);
            issue_reg    <= '0;
            beat_vld_reg <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            count_reg    <= count_next;
            ttl_reg      <= ttl_next;
            issue_reg    <= issue_next;
            beat_vld_reg <= beat_vld_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        info_reg      <= info_next;
        limit_reg     <= limit_next;
        removed_reg   <= removed_next;
        status_reg    <= status_next;
        beat_idx_reg  <= beat_idx_next;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        best_key_reg  <= best_key_next;
        best_info_reg <= best_info_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    // The occupancy counter must track the valid bits exactly.
    `PRTA_ASSERT_IMP(a_count_matches_used, aclk, aresetn, 1'b1, $countones(used_reg) == int'(count_reg))
    `PRTA_ASSERT_IMP(a_count_bounded, aclk, aresetn, 1'b1, count_reg <= CNT_W'(SLOTS))
    // A slot only reaches the compare unit while a scan is running.
    `PRTA_ASSERT_IMP(a_beat_in_scan, aclk, aresetn, beat_vld_reg, state_reg == ST_SCAN)
    // A command transfer always starts work.
    `PRTA_ASSERT_NXT(a_accept_leaves_idle, aclk, aresetn, s_tvalid && s_tready, state_reg != ST_IDLE)

endmodule
